[src/bsfe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfe_pkg
// Shared types, constants and helpers of the byte stream frame extractor.
// ----------------------------------------------------------------------------
package bsfe_pkg;

	localparam logic [11:0] MAX_FRAME   = 12'd2048;
	localparam logic [3:0]  MAX_PATTERN = 4'd8;

	localparam int CMD_DEPTH = 4;
	localparam int CMD_PTR_W = 2;
	localparam int CMD_CNT_W = 3;

	localparam logic [2:0] REG_ENABLE        = 3'd0;
	localparam logic [2:0] REG_FIXED_MODE    = 3'd1;
	localparam logic [2:0] REG_FRAME_LENGTH  = 3'd2;
	localparam logic [2:0] REG_START_PATTERN = 3'd3;
	localparam logic [2:0] REG_START_LENGTH  = 3'd4;
	localparam logic [2:0] REG_END_PATTERN   = 3'd5;
	localparam logic [2:0] REG_END_LENGTH    = 3'd6;

	typedef enum logic {
		CMD_BYTE,
		CMD_START
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t    op;
		logic [7:0] data;
		logic       first;
		logic       last;
		logic       size_cut;
		logic       aborted;
		logic [3:0] count;
	} cmd_t;

	function automatic logic [3:0] pat_len(input logic [3:0] n);
		return (n > MAX_PATTERN) ? MAX_PATTERN : n;
	endfunction

	function automatic logic [63:0] shift_in(input logic [63:0] w, input logic [7:0] b);
		return {b, w[63:8]};
	endfunction

	function automatic logic [3:0] fill_inc(input logic [3:0] f);
		return (f < 4'd8) ? f + 4'd1 : f;
	endfunction

	function automatic logic tail_match(input logic [63:0] w, input logic [63:0] pat,
			input logic [3:0] n);
		logic [63:0] tail;
		logic [63:0] mask;
		tail = w >> (7'd64 - {n[3:0], 3'b000});
		mask = (n >= 4'd8) ? '1 : ((64'd1 << {n[2:0], 3'b000}) - 64'd1);
		return tail == (pat & mask);
	endfunction

endpackage

[src/bsfe_cmd_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfe_cmd_fifo
// Short command queue between the classifier and the result sequencer.
// ----------------------------------------------------------------------------
module bsfe_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  bsfe_pkg::cmd_t wr_data,
	output logic          full,
	input  logic          rd_en,
	output bsfe_pkg::cmd_t rd_data,
	output logic          valid
);
	import bsfe_pkg::*;

	cmd_t                 mem_q [CMD_DEPTH];
	logic [CMD_PTR_W-1:0] rd_ptr_q;
	logic [CMD_PTR_W-1:0] wr_ptr_q;
	logic [CMD_CNT_W-1:0] count_q;

	assign full    = (count_q == CMD_CNT_W'(CMD_DEPTH));
	assign valid   = (count_q != '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CMD_CNT_W'(CMD_DEPTH))
		else $error("command queue overfilled");
	assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en |-> !full) and (rd_en |-> valid))
		else $error("command queue written full or read empty");

endmodule

[src/bsfe_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfe_front
// Configuration registers, pattern windows and frame state; turns each
// accepted item into at most one command for the result sequencer.
// ----------------------------------------------------------------------------
module bsfe_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_wr_en,
	input  logic [2:0]     cfg_index,
	input  logic [63:0]    cfg_data,
	input  logic           accept,
	input  logic           kind,
	input  logic [7:0]     data_byte,
	output logic           cmd_push,
	output bsfe_pkg::cmd_t cmd,
	output logic [63:0]    start_pattern
);
	import bsfe_pkg::*;

	logic        enable_q;
	logic        fixed_mode_q;
	logic [11:0] frame_length_q;
	logic [63:0] start_pattern_q;
	logic [3:0]  start_length_q;
	logic [63:0] end_pattern_q;
	logic [3:0]  end_length_q;

	logic [63:0] start_window_q, start_window_d;
	logic [63:0] end_window_q, end_window_d;
	logic        in_frame_q, in_frame_d;
	logic [11:0] frame_count_q, frame_count_d;
	logic [3:0]  hunt_fill_q, hunt_fill_d;

	logic [3:0]  sl, el;
	logic        emit;
	logic        do_fb;
	logic [11:0] fb_count, fb_cnt, fb_limit;
	logic        fb_end;
	logic [63:0] fb_window, sw;
	logic [3:0]  fb_fill, hf;

	assign start_pattern = start_pattern_q;
	assign cmd_push      = accept && emit;

	always_comb begin
		sl             = pat_len(start_length_q);
		el             = pat_len(end_length_q);
		start_window_d = start_window_q;
		end_window_d   = end_window_q;
		in_frame_d     = in_frame_q;
		frame_count_d  = frame_count_q;
		hunt_fill_d    = hunt_fill_q;
		emit           = 1'b0;
		cmd            = '0;
		cmd.op         = CMD_BYTE;
		cmd.data       = data_byte;
		do_fb          = 1'b0;
		fb_count       = frame_count_q;
		fb_limit       = '0;
		fb_end         = 1'b0;
		fb_window      = end_window_q;
		fb_fill        = hunt_fill_q;
		fb_cnt         = '0;
		sw             = shift_in(start_window_q, data_byte);
		hf             = fill_inc(hunt_fill_q);

		if (kind) begin
			emit           = in_frame_q;
			cmd.data       = '0;
			cmd.last       = 1'b1;
			cmd.aborted    = 1'b1;
			start_window_d = '0;
			end_window_d   = '0;
			in_frame_d     = 1'b0;
			frame_count_d  = '0;
			hunt_fill_d    = '0;
		end else if (!enable_q || (fixed_mode_q && frame_length_q == '0) ||
				(!fixed_mode_q && sl == '0 && el == '0)) begin
			emit      = 1'b1;
			cmd.first = 1'b1;
			cmd.last  = 1'b1;
		end else if (fixed_mode_q) begin
			do_fb    = 1'b1;
			fb_limit = frame_length_q;
		end else begin
			do_fb = 1'b1;
			if (!in_frame_q) begin
				if (sl == '0) begin
					fb_count  = '0;
					fb_window = '0;
					fb_fill   = '0;
				end else begin
					do_fb          = 1'b0;
					start_window_d = sw;
					hunt_fill_d    = hf;
					if (hf >= sl && tail_match(sw, start_pattern_q, sl)) begin
						emit           = 1'b1;
						cmd.op         = CMD_START;
						cmd.count      = sl;
						in_frame_d     = 1'b1;
						frame_count_d  = {8'd0, sl};
						start_window_d = '0;
						end_window_d   = '0;
						hunt_fill_d    = '0;
					end
				end
			end
			if (do_fb) begin
				fb_window = shift_in(fb_window, data_byte);
				fb_fill   = fill_inc(fb_fill);
				fb_end    = (el != '0) && (fb_fill >= el) &&
					tail_match(fb_window, end_pattern_q, el);
			end
		end

		if (do_fb) begin
			emit      = 1'b1;
			fb_cnt    = fb_count + 12'd1;
			cmd.first = (fb_count == '0);
			if (fb_end || (fb_limit != '0 && fb_cnt == fb_limit) || fb_cnt >= MAX_FRAME) begin
				cmd.last       = 1'b1;
				cmd.size_cut   = !(fb_end || (fb_limit != '0 && fb_cnt == fb_limit));
				start_window_d = '0;
				end_window_d   = '0;
				in_frame_d     = 1'b0;
				frame_count_d  = '0;
				hunt_fill_d    = '0;
			end else begin
				in_frame_d    = 1'b1;
				frame_count_d = fb_cnt;
				end_window_d  = fb_window;
				hunt_fill_d   = fb_fill;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q        <= 1'b0;
			fixed_mode_q    <= 1'b0;
			frame_length_q  <= '0;
			start_pattern_q <= '0;
			start_length_q  <= '0;
			end_pattern_q   <= '0;
			end_length_q    <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_ENABLE:        enable_q        <= cfg_data[0];
				REG_FIXED_MODE:    fixed_mode_q    <= cfg_data[0];
				REG_FRAME_LENGTH:  frame_length_q  <= cfg_data[11:0];
				REG_START_PATTERN: start_pattern_q <= cfg_data;
				REG_START_LENGTH:  start_length_q  <= cfg_data[3:0];
				REG_END_PATTERN:   end_pattern_q   <= cfg_data;
				REG_END_LENGTH:    end_length_q    <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_window_q <= '0;
			end_window_q   <= '0;
			in_frame_q     <= 1'b0;
			frame_count_q  <= '0;
			hunt_fill_q    <= '0;
		end else if (accept) begin
			start_window_q <= start_window_d;
			end_window_q   <= end_window_d;
			in_frame_q     <= in_frame_d;
			frame_count_q  <= frame_count_d;
			hunt_fill_q    <= hunt_fill_d;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		!in_frame_q |-> (frame_count_q == '0))
		else $error("byte count left over outside a frame");
	assert property (@(posedge clk) disable iff (!arst_n)
		frame_count_q < MAX_FRAME)
		else $error("open frame reached the size cap");
	assert property (@(posedge clk) disable iff (!arst_n)
		hunt_fill_q <= 4'd8)
		else $error("window fill beyond eight bytes");

endmodule

[src/bsfe_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfe_back
// Result sequencer: expands commands into items and holds the item on offer.
// ----------------------------------------------------------------------------
module bsfe_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  bsfe_pkg::cmd_t cmd,
	output logic           cmd_pop,
	input  logic [63:0]    start_pattern,
	input  logic           pop,
	output logic           empty,
	output logic [7:0]     out_byte,
	output logic           first,
	output logic           last,
	output logic           size_cut,
	output logic           aborted
);
	import bsfe_pkg::*;

	logic       out_valid_q;
	logic [2:0] idx_q;
	logic       load;
	logic       step;
	logic       idx_last;
	logic [7:0] nxt_byte;
	logic       nxt_first;

	assign empty    = !out_valid_q;
	assign load     = !out_valid_q || pop;
	assign step     = load && cmd_valid;
	assign idx_last = ({1'b0, idx_q} + 4'd1) >= cmd.count;
	assign cmd_pop  = step && ((cmd.op == CMD_BYTE) || idx_last);

	always_comb begin
		if (cmd.op == CMD_START) begin
			nxt_byte  = start_pattern[{idx_q, 3'b000} +: 8];
			nxt_first = (idx_q == '0);
		end else begin
			nxt_byte  = cmd.data;
			nxt_first = cmd.first;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_byte <= nxt_byte;
			first    <= nxt_first;
			last     <= (cmd.op == CMD_BYTE) && cmd.last;
			size_cut <= (cmd.op == CMD_BYTE) && cmd.size_cut;
			aborted  <= (cmd.op == CMD_BYTE) && cmd.aborted;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= cmd_valid;
			end
			if (step && cmd.op == CMD_START) begin
				idx_q <= idx_last ? 3'd0 : idx_q + 3'd1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q != '0) |-> (cmd_valid && cmd.op == CMD_START))
		else $error("pattern index set without a start command");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |=> !empty)
		else $error("command retired without an item");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd.op == CMD_START) |-> (cmd.count != '0))
		else $error("empty start command");

endmodule

[src/byte_stream_frame_extractor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_stream_frame_extractor
// Marks frames in a byte stream by start/end patterns or by fixed length.
//
//   channel   handshake            payload
//   input     push / full          kind, data_byte
//   result    pop / empty          out_byte, first, last, size_cut, aborted
//   config    cfg_wr_en            cfg_index, cfg_data
// One input item per cycle unless full; each is classified in the cycle it
// is accepted. A start match yields up to 8 items, one per cycle from the
// sequencer while results are popped; the 4-entry command queue holds later
// commands, then full stalls input. Each result is registered in the queue,
// then in the sequencer output register. Reset clears config and state.
// ----------------------------------------------------------------------------
module byte_stream_frame_extractor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        push,
	output logic        full,
	input  logic        kind,
	input  logic [7:0]  data_byte,
	input  logic        pop,
	output logic        empty,
	output logic [7:0]  out_byte,
	output logic        first,
	output logic        last,
	output logic        size_cut,
	output logic        aborted
);
	import bsfe_pkg::*;

	logic        accept;
	logic        cmd_push;
	cmd_t        cmd_in;
	cmd_t        cmd_head;
	logic        cmd_valid;
	logic        cmd_pop;
	logic [63:0] start_pattern;

	assign accept = push && !full;

	bsfe_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.accept        (accept),
		.kind          (kind),
		.data_byte     (data_byte),
		.cmd_push      (cmd_push),
		.cmd           (cmd_in),
		.start_pattern (start_pattern)
	);

	bsfe_cmd_fifo u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (cmd_in),
		.full    (full),
		.rd_en   (cmd_pop),
		.rd_data (cmd_head),
		.valid   (cmd_valid)
	);

	bsfe_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd_valid),
		.cmd           (cmd_head),
		.cmd_pop       (cmd_pop),
		.start_pattern (start_pattern),
		.pop           (pop),
		.empty         (empty),
		.out_byte      (out_byte),
		.first         (first),
		.last          (last),
		.size_cut      (size_cut),
		.aborted       (aborted)
	);

endmodule
